// ===== design/shabs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shabs_pkg: shared types and constants of the sha-256 byte stream hasher
// round constants, initial chaining words, channel structs and item codes
// ----------------------------------------------------------------------------
package shabs_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BLOCK_W   = 512;
  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned ROUNDS    = 64;
  localparam int unsigned TOTAL_W   = 61;

  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] chain_t;
  typedef logic [BLOCK_W-1:0]                block_t;

  // word 0 sits at packed index 0
  localparam chain_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

endpackage
`default_nettype wire

// ===== design/shabs_compress.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shabs_compress: sha-256 block compression, one round per cycle
// loads a block and the chaining words, runs 64 rounds on a shared round unit
// with a rolling 16-word schedule window, then offers the summed chain
// ----------------------------------------------------------------------------
module shabs_compress import shabs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire block_t    blk,
  input  wire chain_t    chain_in,
  output chain_t         hash_out,
  output cmp_stat_t      stat
);

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  logic [WORD_W-1:0] v_r [NUM_WORDS];
  logic [WORD_W-1:0] w_r [16];
  logic [5:0]        rnd_r;
  logic              busy_r;
  logic              done_r;

  logic [WORD_W-1:0] sig1_e, ch, sig0_a, maj, t1, t2;
  logic [WORD_W-1:0] ws0, ws1, w_new;

  always_comb begin
    sig1_e = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch     = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    sig0_a = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1     = v_r[7] + sig1_e + ch + ROUND_K[rnd_r] + w_r[0];
    t2     = sig0_a + maj;
    ws0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    ws1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new  = w_r[0] + ws0 + w_r[9] + ws1;
  end

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      hash_out[i] = chain_in[i] + v_r[i];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (&rnd_r);
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (&rnd_r) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        v_r[i] <= chain_in[i];
      end
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= blk[BLOCK_W-1-WORD_W*i -: WORD_W];
      end
    end else if (busy_r) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

endmodule
`default_nettype wire

// ===== design/sha256_byte_stream_hasher_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core: sha-256 over a byte stream
// collects bytes into 64-byte blocks, pads on finish and emits eight digest
// words, then returns to the initial chaining words for the next message
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  in      | input     | in_item_t   | in_valid / in_stall
//  out     | output    | out_item_t  | out_valid / out_stall
//
//  a data byte that does not fill a block is taken without a stall
//  a byte that fills a block adds 64 rounds on the round unit, then one
//  chain update before the next byte is taken
//  finish: 9 to 72 pad bytes, one or two compressions,
//  then eight word transfers at up to one per cycle, held by out_stall
//  synchronous active-low reset; in_stall stays high while a block is in work
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core import shabs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_COMP, ST_EMIT} state_t;

  state_t                 state_r;
  logic [5:0]             fill_r;
  logic [TOTAL_W-1:0]     total_r;
  block_t                 blk_r;
  chain_t                 chain_r;
  logic                   fin_r;
  logic                   mark_r;
  logic                   len_r;
  logic [2:0]             emit_idx_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic                   in_acc;
  logic                   push;
  logic [7:0]             push_byte;
  logic [7:0]             pad_byte;
  logic                   pad_len;
  logic [63:0]            bits;
  logic [63:0]            len_sh;
  block_t                 blk_nxt;
  logic                   cmp_start;
  chain_t                 hash_out;
  cmp_stat_t              cmp_stat;
  logic                   out_take;
  logic                   load;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_take  = out_valid_r && !out_stall;
  assign load      = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    bits      = {total_r, 3'b000};
    len_sh    = bits >> {(3'd7 - fill_r[2:0]), 3'b000};
    pad_len   = mark_r && (len_r || (fill_r == LEN_POS));
    pad_byte  = !mark_r ? PAD_MARK : (pad_len ? len_sh[7:0] : 8'h00);
    push      = (state_r == ST_PAD) ||
                ((state_r == ST_IDLE) && in_acc && (in_data.kind == KIND_DATA));
    push_byte = (state_r == ST_PAD) ? pad_byte : in_data.byte_value;
    blk_nxt   = push ? {blk_r[BLOCK_W-9:0], push_byte} : blk_r;
    cmp_start = push && (&fill_r);
  end

  shabs_compress u_compress (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmp_start),
    .blk      (blk_nxt),
    .chain_in (chain_r),
    .hash_out (hash_out),
    .stat     (cmp_stat)
  );

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      chain_r     <= INIT_H;
      fin_r       <= 1'b0;
      mark_r      <= 1'b0;
      len_r       <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.kind == KIND_FINISH) begin
              fin_r   <= 1'b1;
              state_r <= ST_PAD;
            end else begin
              total_r <= total_r + TOTAL_W'(1);
              fill_r  <= fill_r + 6'd1;
              if (cmp_start) begin
                state_r <= ST_COMP;
              end
            end
          end
        end
        ST_PAD: begin
          fill_r <= fill_r + 6'd1;
          if (!mark_r) begin
            mark_r <= 1'b1;
          end else if (pad_len) begin
            len_r <= 1'b1;
          end
          if (cmp_start) begin
            state_r <= ST_COMP;
          end
        end
        ST_COMP: begin
          if (cmp_stat.done) begin
            chain_r <= hash_out;
            if (!fin_r) begin
              state_r <= ST_IDLE;
            end else if (len_r) begin
              state_r <= ST_EMIT;
            end else begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_data_r.digest_word <= chain_r[emit_idx_r];
            out_data_r.word_index  <= emit_idx_r;
            out_data_r.last        <= &emit_idx_r;
            emit_idx_r             <= emit_idx_r + 3'd1;
            if (&emit_idx_r) begin
              chain_r <= INIT_H;
              fill_r  <= '0;
              total_r <= '0;
              fin_r   <= 1'b0;
              mark_r  <= 1'b0;
              len_r   <= 1'b0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_stat.done |-> state_r == ST_COMP)
    else $error("compression finished outside the compress state");

  a_emit_after_length: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> fill_r == '0 && len_r && fin_r)
    else $error("digest emitted before the length block");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_start |-> !cmp_stat.busy && !cmp_stat.done)
    else $error("block started while the round unit is in use");

endmodule
`default_nettype wire
